// ===== sv/b64d_pkg.sv =====
// Package for the Base64 stream decoder.
// Holds the decode job type, the sextet codes and the character map.
// No dependencies.
package b64d_pkg;

	localparam logic [6:0] SEXTET_PAD = 7'd64;
	localparam logic [6:0] SEXTET_BAD = 7'd65;

	typedef struct packed {
		logic [23:0] word;
		logic [1:0]  last_idx;
		logic        eom;
		logic        bad;
	} job_t;

	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [6:0] v;
		v = SEXTET_BAD;
		unique case (c) inside
			[8'h41:8'h5A]: v = 7'(c - 8'h41);
			[8'h61:8'h7A]: v = 7'(c - 8'h61 + 8'd26);
			[8'h30:8'h39]: v = 7'(c - 8'h30 + 8'd52);
			8'h2B:         v = 7'd62;
			8'h2F:         v = 7'd63;
			8'h3D:         v = SEXTET_PAD;
			default:       v = SEXTET_BAD;
		endcase
		return v;
	endfunction

endpackage

// ===== sv/base64_stream_decoder.sv =====
// Base64 stream decoder, top level: front, job queue, back.
// A group's first result word passes the job queue, then the output register.
// Throughput: one character per cycle in unless full, one byte per cycle out on pop.
// full rises only when the job queue holds QUEUE_DEPTH undelivered jobs.
// Reset (arst_n low, asynchronous) clears group state, error flag, queue and output.
// Depends on b64d_pkg, b64d_front, b64d_queue, b64d_back.
module base64_stream_decoder import b64d_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] symbol,
	input  logic       final_symbol,
	input  logic       push,
	output logic       full,
	output logic [7:0] data_byte,
	output logic       end_of_message,
	output logic       bad_message,
	output logic       empty,
	input  logic       pop
);

	job_t fe_job;
	job_t head_job;
	logic fe_push;
	logic head_valid;
	logic head_pop;
	logic accept;

	assign accept = push && !full;

	b64d_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.symbol       (symbol),
		.final_symbol (final_symbol),
		.job_push     (fe_push),
		.job          (fe_job)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (fe_push),
		.push_job   (fe_job),
		.full       (full),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (head_pop)
	);

	b64d_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head_job       (head_job),
		.head_pop       (head_pop),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.bad_message    (bad_message),
		.empty          (empty),
		.pop            (pop)
	);

endmodule

// ===== sv/b64d_front.sv =====
// Front end of the Base64 stream decoder: classify characters, gather groups.
// Emits one decode job per finished group or per failed message.
// Depends on b64d_pkg.
module b64d_front import b64d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] symbol,
	input  logic       final_symbol,
	output logic       job_push,
	output job_t       job
);

	logic [17:0] gather_q;
	logic [1:0]  pos_q;
	logic [1:0]  pad_seen_q;
	logic        err_q;

	logic [17:0] gather_n;
	logic [1:0]  pos_n;
	logic [1:0]  pad_seen_n;
	logic        err_n;
	logic [6:0]  v;
	logic        is_pad;
	logic [5:0]  bits;
	logic [1:0]  pads;
	logic        emit_data;

	always_comb begin
		v          = sextet_of(symbol);
		is_pad     = (v == SEXTET_PAD);
		bits       = is_pad ? 6'd0 : v[5:0];
		pads       = pad_seen_q + {1'b0, is_pad};
		gather_n   = gather_q;
		pos_n      = pos_q;
		pad_seen_n = pad_seen_q;
		err_n      = err_q;
		emit_data  = 1'b0;
		if (!err_q) begin
			if (v == SEXTET_BAD) begin
				err_n = 1'b1;
			end else if (is_pad && pos_q < 2'd2) begin
				err_n = 1'b1;
			end else if (!is_pad && pad_seen_q != 2'd0) begin
				err_n = 1'b1;
			end else if (pos_q < 2'd3) begin
				gather_n   = {gather_q[11:0], bits};
				pad_seen_n = pad_seen_q + {1'b0, is_pad};
				pos_n      = pos_q + 2'd1;
				if (final_symbol) begin
					err_n = 1'b1;
				end
			end else if (pads != 2'd0 && !final_symbol) begin
				err_n = 1'b1;
			end else begin
				emit_data  = 1'b1;
				gather_n   = '0;
				pos_n      = '0;
				pad_seen_n = '0;
			end
		end
		if (final_symbol) begin
			gather_n   = '0;
			pos_n      = '0;
			pad_seen_n = '0;
		end
	end

	always_comb begin
		job      = '{word: {gather_q, bits}, last_idx: 2'd2 - pads,
		             eom: final_symbol, bad: 1'b0};
		job_push = accept && emit_data;
		if (final_symbol && err_n) begin
			job      = '{word: '0, last_idx: 2'd0, eom: 1'b1, bad: 1'b1};
			job_push = accept;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gather_q   <= '0;
			pos_q      <= '0;
			pad_seen_q <= '0;
			err_q      <= 1'b0;
		end else if (accept) begin
			gather_q   <= gather_n;
			pos_q      <= pos_n;
			pad_seen_q <= pad_seen_n;
			err_q      <= err_n && !final_symbol;
		end
	end

endmodule

// ===== sv/b64d_queue.sv =====
// Job queue between front and back of the Base64 stream decoder.
// Small register FIFO with combinational head read.
// Depends on b64d_pkg.
module b64d_queue import b64d_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	output logic head_valid,
	output job_t head_job,
	input  logic pop
);

	localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	logic do_push;
	logic do_pop;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job   = mem_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
		end
	end

endmodule

// ===== sv/b64d_back.sv =====
// Back end of the Base64 stream decoder: split jobs into result words.
// One byte per cycle into an output register while it is empty or popped.
// Depends on b64d_pkg.
module b64d_back import b64d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  job_t       head_job,
	output logic       head_pop,
	output logic [7:0] data_byte,
	output logic       end_of_message,
	output logic       bad_message,
	output logic       empty,
	input  logic       pop
);

	logic [1:0] k_q;
	logic       valid_q;
	logic [7:0] data_q;
	logic       eom_q;
	logic       bad_q;

	logic       load;
	logic       take;
	logic       last;
	logic [7:0] sel_byte;

	always_comb begin
		load = !valid_q || pop;
		take = load && head_valid;
		last = (k_q == head_job.last_idx);
		head_pop = take && last;
		case (k_q)
			2'd0:    sel_byte = head_job.word[23:16];
			2'd1:    sel_byte = head_job.word[15:8];
			default: sel_byte = head_job.word[7:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_q <= sel_byte;
			eom_q  <= head_job.eom && last;
			bad_q  <= head_job.bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= head_valid;
			end
			if (take) begin
				k_q <= last ? 2'd0 : k_q + 2'd1;
			end
		end
	end

	assign data_byte      = data_q;
	assign end_of_message = eom_q;
	assign bad_message    = bad_q;
	assign empty          = !valid_q;

endmodule

// ===== tb/b64_decode_checker.sv =====
// Scoreboard for the Base64 stream decoder: predicts the output words from the accepted
// characters and compares each popped word with the oldest prediction.
// Depends on b64d_pkg for the sextet codes.
`timescale 1ns / 100ps

module b64_decode_checker import b64d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] symbol,
	input  logic       final_symbol,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] data_byte,
	input  logic       end_of_message,
	input  logic       bad_message,
	input  logic       empty,
	input  logic       pop,
	output int         mismatches,
	output int         waiting
);

	typedef struct packed {
		logic [7:0] data;
		logic       eom;
		logic       bad;
	} out_word_t;

	out_word_t   expected_words[$];
	logic [17:0] gather    = '0;
	logic [1:0]  group_pos = '0;
	logic [1:0]  pad_count = '0;
	logic        bad_seen  = 1'b0;
	int          fails     = 0;

	function automatic logic [6:0] char_value(input logic [7:0] c);
		if (c >= "A" && c <= "Z") return 7'(c - "A");
		if (c >= "a" && c <= "z") return 7'(c - "a" + 26);
		if (c >= "0" && c <= "9") return 7'(c - "0" + 52);
		if (c == "+") return 7'd62;
		if (c == "/") return 7'd63;
		if (c == "=") return SEXTET_PAD;
		return SEXTET_BAD;
	endfunction

	task automatic decode_symbol(input logic [7:0] c, input logic fin);
		logic [6:0]  v;
		logic        is_pad;
		logic [5:0]  bits;
		logic [23:0] group;
		int          total_pads;
		int          n_bytes;
		out_word_t   w;
		if (!bad_seen) begin
			v = char_value(c);
			is_pad = (v == SEXTET_PAD);
			bits = is_pad ? 6'd0 : v[5:0];
			if (v == SEXTET_BAD) begin
				bad_seen = 1'b1;
			end else if (is_pad && group_pos < 2) begin
				bad_seen = 1'b1;
			end else if (!is_pad && pad_count != 0) begin
				bad_seen = 1'b1;
			end else if (group_pos < 3) begin
				gather = {gather[11:0], bits};
				if (is_pad) pad_count = pad_count + 2'd1;
				group_pos = group_pos + 2'd1;
				if (fin) bad_seen = 1'b1;
			end else begin
				total_pads = pad_count + (is_pad ? 1 : 0);
				if (total_pads != 0 && !fin) begin
					bad_seen = 1'b1;
				end else begin
					group = {gather, bits};
					n_bytes = 3 - total_pads;
					for (int k = 0; k < n_bytes; k++) begin
						w.data = group[23 - 8 * k -: 8];
						w.eom = fin && (k == n_bytes - 1);
						w.bad = 1'b0;
						expected_words.push_back(w);
					end
					gather = '0;
					group_pos = '0;
					pad_count = '0;
				end
			end
		end
		if (fin) begin
			if (bad_seen) begin
				w.data = 8'h00;
				w.eom = 1'b1;
				w.bad = 1'b1;
				expected_words.push_back(w);
			end
			gather = '0;
			group_pos = '0;
			pad_count = '0;
			bad_seen = 1'b0;
		end
	endtask

	always @(posedge clk) begin
		out_word_t got;
		out_word_t want;
		if (arst_n) begin
			if (push && !full) decode_symbol(symbol, final_symbol);
			if (pop && !empty) begin
				got.data = data_byte;
				got.eom = end_of_message;
				got.bad = bad_message;
				if (expected_words.size() == 0) begin
					fails++;
					$display("%0t: unexpected word data=%h eom=%b bad=%b",
						$time, got.data, got.eom, got.bad);
				end else begin
					want = expected_words.pop_front();
					if (got.data !== want.data || got.eom !== want.eom ||
							got.bad !== want.bad) begin
						fails++;
						$display("%0t: mismatch expected data=%h eom=%b bad=%b, got data=%h eom=%b bad=%b",
							$time, want.data, want.eom, want.bad,
							got.data, got.eom, got.bad);
					end
				end
			end
		end
		mismatches <= fails;
		waiting <= expected_words.size();
	end

endmodule

// ===== tb/tb.sv =====
// Top of the Base64 stream decoder testbench: clock, reset, character stimulus and
// output pacing; the verdict comes from the failure and waiting counts of b64_decode_checker.
// Depends on base64_stream_decoder and b64_decode_checker.
`timescale 1ns / 100ps

module tb;

	localparam int ITEM_TARGET = 270;
	localparam int IDLE_LIMIT  = 5000;
	localparam int LONG_HOLD   = 100;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic [7:0] symbol       = '0;
	logic       final_symbol = 1'b0;
	logic       push         = 1'b0;
	logic       pop          = 1'b0;
	logic       full;
	logic [7:0] data_byte;
	logic       end_of_message;
	logic       bad_message;
	logic       empty;
	int         mismatches;
	int         waiting;

	string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	int    items_sent    = 0;
	int    burst_left    = 0;
	bit    long_hold_req = 1'b0;
	int    idle_cycles   = 0;

	base64_stream_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.symbol(symbol),
		.final_symbol(final_symbol),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.end_of_message(end_of_message),
		.bad_message(bad_message),
		.empty(empty),
		.pop(pop)
	);

	b64_decode_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.symbol(symbol),
		.final_symbol(final_symbol),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.end_of_message(end_of_message),
		.bad_message(bad_message),
		.empty(empty),
		.pop(pop),
		.mismatches(mismatches),
		.waiting(waiting)
	);

	always #2 clk = ~clk;

	task automatic offer(input logic [7:0] c, input logic fin);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		push <= 1'b1;
		symbol <= c;
		final_symbol <= fin;
		@(posedge clk);
		while (full) @(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	task automatic send_text(input string s, input bit last_final);
		for (int i = 0; i < s.len(); i++)
			offer(s[i], last_final && (i == s.len() - 1));
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		do @(posedge clk); while (waiting != 0);
	endtask

	task automatic send_random_message();
		logic [7:0] chars[$];
		int         groups;
		int         pads;
		int         fault;
		int         pos;
		groups = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
		for (int i = 0; i < 4 * groups; i++)
			chars.push_back(alphabet[$urandom_range(0, 63)]);
		pads = $urandom_range(0, 2);
		if (pads >= 1) chars[chars.size() - 1] = "=";
		if (pads == 2) chars[chars.size() - 2] = "=";
		fault = $urandom_range(0, 9);
		pos = $urandom_range(0, chars.size() - 1);
		case (fault)
			0: chars[pos] = 8'($urandom_range(0, 255));
			1: chars.pop_back();
			2: chars[pos] = "=";
			3: chars.push_back(alphabet[$urandom_range(0, 63)]);
			default: ;
		endcase
		for (int i = 0; i < chars.size(); i++)
			offer(chars[i], i == chars.size() - 1);
	endtask

	// receiver: random pacing in phases, plus a long hold on request
	initial begin
		int mode;
		int phase_left;
		mode = 0;
		phase_left = 0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				pop <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (phase_left == 0) begin
					mode = $urandom_range(0, 2);
					phase_left = $urandom_range(10, 60);
				end
				phase_left--;
				case (mode)
					0: pop <= 1'b1;
					1: pop <= 1'($urandom_range(0, 1));
					default: pop <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int message_count;
		message_count = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("TWFu", 1'b1);
		send_text("QR==", 1'b1);
		send_text("//9=", 1'b1);
		offer(8'hFF, 1'b1);
		offer(8'h00, 1'b0);
		offer("A", 1'b1);
		send_text("A===", 1'b1);
		send_text("QQ", 1'b1);
		send_text("QQ=A", 1'b1);
		send_text("QQ==", 1'b0);
		send_text("A", 1'b1);
		wait_drained();

		while (items_sent < ITEM_TARGET) begin
			send_random_message();
			message_count++;
			if (message_count == 6 || message_count == 22) long_hold_req = 1'b1;
			if (message_count == 14 || message_count == 30) wait_drained();
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && waiting == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== base64_stream_decoder.f =====
sv/b64d_pkg.sv
sv/b64d_front.sv
sv/b64d_queue.sv
sv/b64d_back.sv
sv/base64_stream_decoder.sv
tb/b64_decode_checker.sv
tb/tb.sv
